/* src/bsw_pkg.sv */
`timescale 1ns / 1ps

package bsw_pkg;

  // Field widths and fixed-point formats
  localparam int COORD_W          = 32;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WORK_FRAC_BITS   = 32;
  localparam int MAX_DEGREE       = 7;
  localparam int NUM_TAPS         = MAX_DEGREE + 1;
  localparam int DEG_W            = 3;
  localparam int INDEX_W          = 17;
  localparam int WEIGHT_W         = 17;
  localparam logic [DEG_W-1:0] DEG_RESET = 3'd3;

  // Recursion datapath
  localparam int CUR_W   = WORK_FRAC_BITS + 2;            // stage value, a little over 1.0
  localparam int FAC_W   = COORD_FRAC_BITS + 4;           // t + k*one, k <= 7
  localparam int SUM_W   = FAC_W + CUR_W + 1;             // sum of two products
  localparam int LO_W    = 18;                            // low digit of the constant divide
  localparam int H_W     = SUM_W - COORD_FRAC_BITS - LO_W; // high digit
  localparam int REC_SH  = 24;                            // reciprocal scale, >= H_W + 3
  localparam int REC_W   = REC_SH + 1;
  localparam int DPROD_W = H_W + REC_W;
  localparam int W_SH    = WORK_FRAC_BITS - WEIGHT_FRAC_BITS;
  localparam int RND_W   = CUR_W + 1 - W_SH;

  // Pipeline: entry stage, three stages per recursion level, output stage
  localparam int NUM_STAGES = 3 * MAX_DEGREE + 2;
  localparam int OUT_STAGE  = NUM_STAGES - 1;
  localparam int LAST_T     = 3 * MAX_DEGREE - 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

  // ceil(2^REC_SH / n): exact quotient for dividends below 2^H_W
  function automatic logic [REC_W-1:0] recip(input logic [DEG_W-1:0] n);
    logic [REC_W-1:0] r;
    unique case (n)
      3'd2:    r = 25'd8388608;
      3'd3:    r = 25'd5592406;
      3'd4:    r = 25'd4194304;
      3'd5:    r = 25'd3355444;
      3'd6:    r = 25'd2796203;
      3'd7:    r = 25'd2396746;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

/* src/bsw_if.sv */
`timescale 1ns / 1ps

interface bsw_coord_if import bsw_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coordinate;

  modport source (output valid, output coordinate, input ready);
  modport sink   (input valid, input coordinate, output ready);
endinterface

interface bsw_result_if import bsw_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [INDEX_W-1:0]  base_index;
  logic        [WEIGHT_W-1:0] weight_0;
  logic        [WEIGHT_W-1:0] weight_1;
  logic        [WEIGHT_W-1:0] weight_2;
  logic        [WEIGHT_W-1:0] weight_3;
  logic        [WEIGHT_W-1:0] weight_4;
  logic        [WEIGHT_W-1:0] weight_5;
  logic        [WEIGHT_W-1:0] weight_6;
  logic        [WEIGHT_W-1:0] weight_7;

  modport source (output valid, output base_index, output weight_0, output weight_1,
                  output weight_2, output weight_3, output weight_4, output weight_5,
                  output weight_6, output weight_7, input ready);
  modport sink   (input valid, input base_index, input weight_0, input weight_1,
                  input weight_2, input weight_3, input weight_4, input weight_5,
                  input weight_6, input weight_7, output ready);
endinterface

/* src/bspline_basis_weights_top.sv */
`timescale 1ns / 1ps

// Channel    Dir  Handshake      Item
// coord_i    in   valid/ready    coordinate, signed Q16.16
// result_o   out  valid/ready    base_index (17b signed), weight_0..weight_7 (unsigned Q1.16)
// cfg        in   cfg_we_i only  spline_degree in cfg_wdata_i, reset 3
//
// One item per cycle while the output is not stalled. The pipe has an entry stage, three
// stages for each of the seven Cox-de Boor levels (multiply-add, high digit of the divide
// by n, low digit) and a rounding/output stage. Levels above the configured degree pass
// values through. Reset clears only the valid bits and sets the degree register to 3.
// Each stage holds while it is full and the one after it cannot take its item; empty
// stages keep filling, so bubbles close up under an output stall.

module bspline_basis_weights_top import bsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DEG_W-1:0] cfg_wdata_i,
  bsw_coord_if.sink        coord_i,
  bsw_result_if.source     result_o
);

  // ---------------------------------------------------------------- config
  logic [DEG_W-1:0] deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= DEG_RESET;
    end else if (cfg_we_i) begin
      deg_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- flow control
  // rdy[k]: stage k may load this cycle (empty, or its item moves on).
  logic [NUM_STAGES-1:0] v_q, v_d, rdy;

  assign rdy[OUT_STAGE] = !v_q[OUT_STAGE] || result_o.ready;
  assign v_d[0]         = rdy[0] ? coord_i.valid : v_q[0];

  for (genvar k = 0; k < OUT_STAGE; k++) begin : g_rdy
    assign rdy[k]   = !v_q[k] || rdy[k+1];
    assign v_d[k+1] = rdy[k+1] ? v_q[k] : v_q[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign coord_i.ready  = rdy[0];
  assign result_o.valid = v_q[OUT_STAGE];

  // ---------------------------------------------------------------- entry stage
  // shifted = x + (1 - d) * one/2; base is its integer part, t its fraction.
  logic signed [DEG_W+1:0]   one_minus_d;
  logic signed [COORD_W+1:0] shifted;

  assign one_minus_d = (DEG_W+2)'(signed'(1)) - $signed({2'b00, deg_q});
  assign shifted     = (COORD_W+2)'(coord_i.coordinate)
                     + ((COORD_W+2)'(one_minus_d) <<< (COORD_FRAC_BITS - 1));

  logic [INDEX_W-1:0]         base_q [OUT_STAGE+1];
  logic [COORD_FRAC_BITS-1:0] t_q    [LAST_T+1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      base_q[0] <= shifted[COORD_FRAC_BITS +: INDEX_W];
      t_q[0]    <= shifted[COORD_FRAC_BITS-1:0];
    end
  end

  // base and fraction ride along the pipe
  for (genvar k = 1; k <= OUT_STAGE; k++) begin : g_base
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        base_q[k] <= base_q[k-1];
      end
    end
  end

  for (genvar k = 1; k <= LAST_T; k++) begin : g_frac
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        t_q[k] <= t_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- recursion levels
  // cur_w[n]: stage values after level n; level 0 is the constant one.
  wire [CUR_W-1:0] cur_w [MAX_DEGREE+1][NUM_TAPS];

  for (genvar i = 0; i < NUM_TAPS; i++) begin : g_init
    assign cur_w[0][i] = (i == 0) ? (CUR_W'(1) << WORK_FRAC_BITS) : '0;
  end

  for (genvar n = 1; n <= MAX_DEGREE; n++) begin : g_lvl
    localparam int SA = 3 * n - 2;
    localparam int SB = 3 * n - 1;
    localparam int SC = 3 * n;
    localparam logic [REC_W-1:0] RECIP = recip(DEG_W'(n));

    // above the degree the level multiplies by n*one, and the divide undoes it
    logic bypass;
    assign bypass = DEG_W'(n) > deg_q;

    for (genvar i = 0; i < NUM_TAPS; i++) begin : g_lane
      localparam int IA = (i > 0) ? i - 1 : 0;
      localparam int KA = (n > i) ? n - i : 0;

      logic [FAC_W-1:0]   fa, fb;
      logic [CUR_W-1:0]   a, b;
      logic [SUM_W-1:0]   num_d, num_q;
      logic [SUM_W-1:0]   u;
      logic [H_W-1:0]     h, rem;
      logic [DPROD_W-1:0] ph, pl;
      logic [H_W-1:0]     qh, qh_q;
      logic [DEG_W-1:0]   rh_q;
      logic [LO_W-1:0]    lo_q, ql;
      logic [CUR_W-1:0]   cur_q;

      // stage A: (t + n - i) * c[i-1] + (i + 1 - t) * c[i]
      always_comb begin
        fa = '0;
        fb = '0;
        a  = '0;
        b  = '0;
        if (bypass) begin
          fb = FAC_W'(n) << COORD_FRAC_BITS;
          b  = cur_w[n-1][i];
        end else begin
          if (i > 0 && i <= n) begin
            fa = FAC_W'(t_q[SA-1]) + (FAC_W'(KA) << COORD_FRAC_BITS);
            a  = cur_w[n-1][IA];
          end
          if (i < n) begin
            fb = (FAC_W'(i + 1) << COORD_FRAC_BITS) - FAC_W'(t_q[SA-1]);
            b  = cur_w[n-1][i];
          end
        end
        num_d = SUM_W'(fa * a) + SUM_W'(fb * b);
      end

      always_ff @(posedge clk_i) begin
        if (rdy[SA]) begin
          num_q <= num_d;
        end
      end

      // stage B: round half up, drop the fraction, divide high digit by n
      assign u   = num_q + (SUM_W'(n) << (COORD_FRAC_BITS - 1));
      assign h   = u[SUM_W-1 -: H_W];
      assign ph  = DPROD_W'(h) * DPROD_W'(RECIP);
      assign qh  = ph[REC_SH +: H_W];
      assign rem = h - qh * H_W'(n);

      always_ff @(posedge clk_i) begin
        if (rdy[SB]) begin
          qh_q <= qh;
          rh_q <= rem[DEG_W-1:0];
          lo_q <= u[COORD_FRAC_BITS +: LO_W];
        end
      end

      // stage C: remainder and low digit divided by n
      assign pl = DPROD_W'(H_W'({rh_q, lo_q})) * DPROD_W'(RECIP);
      assign ql = pl[REC_SH +: LO_W];

      always_ff @(posedge clk_i) begin
        if (rdy[SC]) begin
          cur_q <= CUR_W'({qh_q, ql});
        end
      end

      assign cur_w[n][i] = cur_q;
    end
  end

  // ---------------------------------------------------------------- output stage
  logic [WEIGHT_W-1:0] w_q [NUM_TAPS];

  for (genvar i = 0; i < NUM_TAPS; i++) begin : g_out
    logic [CUR_W:0]      rsum;
    logic [RND_W-1:0]    rnd;
    logic [WEIGHT_W-1:0] w_d;

    assign rsum = (CUR_W+1)'(cur_w[MAX_DEGREE][i]) + ((CUR_W+1)'(1) << (W_SH - 1));
    assign rnd  = rsum[CUR_W:W_SH];

    always_comb begin
      if (DEG_W'(i) > deg_q) begin
        w_d = '0;
      end else if (rnd > RND_W'(WEIGHT_ONE)) begin
        w_d = WEIGHT_ONE;
      end else begin
        w_d = WEIGHT_W'(rnd);
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[OUT_STAGE]) begin
        w_q[i] <= w_d;
      end
    end
  end

  assign result_o.base_index = base_q[OUT_STAGE];
  assign result_o.weight_0   = w_q[0];
  assign result_o.weight_1   = w_q[1];
  assign result_o.weight_2   = w_q[2];
  assign result_o.weight_3   = w_q[3];
  assign result_o.weight_4   = w_q[4];
  assign result_o.weight_5   = w_q[5];
  assign result_o.weight_6   = w_q[6];
  assign result_o.weight_7   = w_q[7];

endmodule

/* src/bsw_checker.sv */
`timescale 1ns / 1ps

module bsw_checker import bsw_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [DEG_W-1:0]    cfg_wdata_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [WEIGHT_W-1:0] weight_0_i,
  input logic [WEIGHT_W-1:0] weight_7_i
);

  logic [DEG_W-1:0] deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= DEG_RESET;
    end else if (cfg_we_i) begin
      deg_q <= cfg_wdata_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> weight_0_i <= WEIGHT_ONE && weight_7_i <= WEIGHT_ONE)
    else $error("weight above 1.0");

  a_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && deg_q != DEG_W'(MAX_DEGREE) |-> weight_7_i == '0)
    else $error("unused tap carries weight");

  a_deg0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && deg_q == '0 |-> weight_0_i == WEIGHT_ONE)
    else $error("degree zero weight not one");

endmodule

bind bspline_basis_weights_top bsw_checker u_bsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .weight_0_i  (result_o.weight_0),
  .weight_7_i  (result_o.weight_7)
);
